FILE: sv/udpdmx_pkg.sv
// udpdmx_pkg: shared types and constants for the udp port demux with receive queues
// no dependencies
`default_nettype none
package udpdmx_pkg;
    localparam logic [1:0] MODE_BIND   = 2'd0;
    localparam logic [1:0] MODE_UNBIND = 2'd1;
    localparam logic [1:0] MODE_ARRIVE = 2'd2;
    localparam logic [1:0] MODE_RECV   = 2'd3;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_FULL     = 2'd1;
    localparam logic [1:0] ST_UNBOUND  = 2'd2;
    localparam logic [1:0] ST_EMPTY    = 2'd3;

    localparam logic [15:0] LOW_PORT_LIMIT   = 16'd1024;
    localparam logic [15:0] PORT_DHCP_CLIENT = 16'd68;
    localparam logic [15:0] PORT_TFTP        = 16'd69;
    localparam logic [15:0] PORT_NTP         = 16'd123;
    localparam logic [15:0] HEADER_BYTES     = 16'd8;

    typedef enum logic [6:0] {
        S_IDLE   = 7'b0000001,
        S_SCAN   = 7'b0000010,
        S_RESP   = 7'b0000100,
        S_RDLEN  = 7'b0001000,
        S_RDSET  = 7'b0010000,
        S_RDBYTE = 7'b0100000,
        S_EMIT   = 7'b1000000
    } state_t;
endpackage
`default_nettype wire

FILE: sv/udp_port_demux_rx_queues_core.sv
// udp_port_demux_rx_queues_core: port table, per-port packet rings, byte-wise receive
// depends on udpdmx_pkg
// bind/unbind/arrival-header scan: one slot per cycle
// arrival bytes after the first are stored as accepted; the first byte once the scan ends
// receive: ring check, then per byte S_RDSET read, S_RDBYTE (length, first byte), S_EMIT output
// throughput limited by the single shared slot comparator and one payload write and read port
// reset: port table, ring pointers and arrival state clear asynchronously; stores undefined
`default_nettype none
module udp_port_demux_rx_queues_core
    import udpdmx_pkg::*;
#(
    parameter int PORT_SLOTS    = 4,
    parameter int QUEUE_DEPTH   = 2,
    parameter int PAYLOAD_BYTES = 64
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // port, source_ip, src_port, udp_length, data_byte, slot_index, read_limit, zero pad
    input  wire logic [111:0] s_tdata,
    // mode, byte_valid
    input  wire logic [2:0]  s_tuser,
    input  wire logic        s_tlast,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // status, slot, delivered_length, payload_byte, sender_ip, sender_port, zero pad
    output logic [71:0]      m_tdata,
    // payload_valid
    output logic             m_tuser,
    output logic             m_tlast
);
    localparam int SW = (PORT_SLOTS > 1) ? $clog2(PORT_SLOTS) : 1;
    localparam int QW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int BW = (PAYLOAD_BYTES > 1) ? $clog2(PAYLOAD_BYTES) : 1;
    localparam int ENT = PORT_SLOTS * QUEUE_DEPTH;
    localparam int EW = (ENT > 1) ? $clog2(ENT) : 1;
    localparam int AW = EW + BW;
    localparam int PDEPTH = ENT * (1 << BW);
    localparam logic [6:0] CAP = 7'(PAYLOAD_BYTES);

    wire logic [1:0]  in_mode  = s_tuser[1:0];
    wire logic [15:0] in_port  = s_tdata[15:0];
    wire logic [31:0] in_ip    = s_tdata[47:16];
    wire logic [15:0] in_sport = s_tdata[63:48];
    wire logic [15:0] in_ulen  = s_tdata[79:64];
    wire logic [7:0]  in_byte  = s_tdata[87:80];
    wire logic        in_bval  = s_tuser[2];
    wire logic [3:0]  in_slot  = s_tdata[91:88];
    wire logic [15:0] in_limit = s_tdata[107:92];

    logic [15:0]   port_table_reg [PORT_SLOTS];
    logic [QW-1:0] wptr_reg [PORT_SLOTS];
    logic [QW-1:0] rptr_reg [PORT_SLOTS];

    logic [7:0]  payload_mem [PDEPTH];
    logic [31:0] ip_mem   [ENT];
    logic [15:0] sport_mem[ENT];
    logic [6:0]  len_mem  [ENT];

    state_t      state_reg;
    logic [1:0]  mode_reg;
    logic [15:0] port_reg;
    logic [SW:0] idx_reg;
    logic        hdr_last_reg;
    logic [7:0]  hdr_byte_reg;
    logic        hdr_bval_reg;

    logic        a_active_reg, a_accept_reg;
    logic [SW-1:0] a_slot_reg;
    logic [6:0]  a_count_reg, a_cap_reg;
    logic [31:0] a_ip_reg;
    logic [15:0] a_sport_reg;

    logic [3:0]  r_slot_reg;
    logic [15:0] r_limit_reg;
    logic [EW-1:0] r_ent_reg;
    logic [6:0]  r_n_reg, r_k_reg;
    logic [7:0]  rd_byte_reg;
    logic [31:0] rd_ip_reg;
    logic [15:0] rd_sport_reg;
    logic [6:0]  rd_len_reg;

    logic        out_valid_reg;
    logic [72:0] out_data_reg;
    logic        out_last_reg;

    assign s_tready = (state_reg == S_IDLE) && !out_valid_reg;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg[71:0];
    assign m_tuser  = out_data_reg[72];
    assign m_tlast  = out_last_reg;

    wire logic acc = s_tvalid && s_tready;
    wire logic [SW-1:0] idx = idx_reg[SW-1:0];
    wire logic scan_done = (idx_reg == (SW+1)'(PORT_SLOTS));
    wire logic [15:0] hit_port = port_table_reg[idx];
    wire logic port_ok = (port_reg >= LOW_PORT_LIMIT) || (port_reg == PORT_DHCP_CLIENT)
                      || (port_reg == PORT_TFTP) || (port_reg == PORT_NTP);

    function automatic logic [72:0] pack_out(logic [1:0] st, logic [3:0] sl, logic [6:0] dl,
                                             logic [7:0] b, logic bv, logic [31:0] ip,
                                             logic [15:0] sp);
        pack_out = {bv, 3'd0, sp, ip, b, dl, sl, st};
    endfunction

    function automatic logic [EW-1:0] ent_of(logic [SW-1:0] s, logic [QW-1:0] p);
        logic [EW+SW:0] t;
        t = (EW+SW+1)'(s) * (EW+SW+1)'(QUEUE_DEPTH) + (EW+SW+1)'(p);
        ent_of = t[EW-1:0];
    endfunction

    function automatic logic [QW-1:0] inc_ptr(logic [QW-1:0] p);
        logic [QW:0] t;
        t = {1'b0, p} + 1'b1;
        if (t >= (QW+1)'(QUEUE_DEPTH)) t = '0;
        inc_ptr = t[QW-1:0];
    endfunction

    // arrival byte store, shared by first-byte path and later bytes
    logic        wr_en;
    logic [7:0]  wr_byte;
    logic        wr_bval, wr_last;
    always_comb
    begin
        wr_en = 1'b0; wr_byte = in_byte; wr_bval = in_bval; wr_last = s_tlast;
        if (state_reg == S_SCAN && mode_reg == MODE_ARRIVE && (scan_done || !port_ok ||
            hit_port == port_reg))
        begin
            wr_en = 1'b1; wr_byte = hdr_byte_reg; wr_bval = hdr_bval_reg; wr_last = hdr_last_reg;
        end
        else if (acc && in_mode == MODE_ARRIVE && a_active_reg)
            wr_en = 1'b1;
    end
    wire logic w_accept = (state_reg == S_SCAN) ? (port_ok && !scan_done && hit_port == port_reg)
                                                 : a_accept_reg;
    wire logic [SW-1:0] w_slot = (state_reg == S_SCAN) ? idx : a_slot_reg;
    wire logic [EW-1:0] w_ent = ent_of(w_slot, wptr_reg[w_slot]);

    always_ff @(posedge clk)
    begin
        if (wr_en && w_accept)
        begin
            if (wr_bval && a_count_reg < a_cap_reg)
                payload_mem[AW'({w_ent, a_count_reg[BW-1:0]})] <= wr_byte;
            if (wr_last)
            begin
                ip_mem[w_ent] <= a_ip_reg;
                sport_mem[w_ent] <= a_sport_reg;
                len_mem[w_ent] <= a_cap_reg;
            end
        end
        rd_byte_reg  <= payload_mem[AW'({r_ent_reg, r_k_reg[BW-1:0]})];
        rd_ip_reg    <= ip_mem[r_ent_reg];
        rd_sport_reg <= sport_mem[r_ent_reg];
        rd_len_reg   <= len_mem[r_ent_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            out_valid_reg <= 1'b0;
            a_active_reg <= 1'b0;
            a_accept_reg <= 1'b0;
            for (int i = 0; i < PORT_SLOTS; i++)
            begin
                port_table_reg[i] <= '0; wptr_reg[i] <= '0; rptr_reg[i] <= '0;
            end
        end
        else
        begin
            if (out_valid_reg && m_tready && state_reg != S_EMIT) out_valid_reg <= 1'b0;
            if (wr_en)
            begin
                if (w_accept && wr_bval && a_count_reg < a_cap_reg)
                    a_count_reg <= a_count_reg + 7'd1;
                if (w_accept && wr_last) wptr_reg[w_slot] <= inc_ptr(wptr_reg[w_slot]);
                a_active_reg <= !wr_last;
                if (state_reg == S_SCAN)
                begin
                    a_accept_reg <= w_accept;
                    a_slot_reg <= w_slot;
                end
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (acc)
                    begin
                        mode_reg <= in_mode; port_reg <= in_port;
                        idx_reg <= '0;
                        hdr_last_reg <= s_tlast; hdr_byte_reg <= in_byte;
                        hdr_bval_reg <= in_bval;
                        r_slot_reg <= in_slot; r_limit_reg <= in_limit;
                        if (in_mode == MODE_ARRIVE)
                        begin
                            if (!a_active_reg)
                            begin
                                a_count_reg <= '0;
                                a_cap_reg <= ((in_ulen - HEADER_BYTES) < 16'(CAP)) ?
                                             7'(in_ulen - HEADER_BYTES) : CAP;
                                a_ip_reg <= in_ip; a_sport_reg <= in_sport;
                                state_reg <= S_SCAN;
                            end
                        end
                        else if (in_mode == MODE_RECV)
                            state_reg <= S_RDLEN;
                        else
                            state_reg <= S_SCAN;
                    end
                end
                S_SCAN:
                begin
                    idx_reg <= idx_reg + 1'b1;
                    case (mode_reg)
                        MODE_BIND:
                        begin
                            if (scan_done)
                            begin
                                out_data_reg <= pack_out(ST_FULL, 4'd0, '0, '0, 1'b0, '0, '0);
                                out_last_reg <= 1'b1; out_valid_reg <= 1'b1; state_reg <= S_IDLE;
                            end
                            else if (hit_port == port_reg || hit_port == 16'd0)
                            begin
                                if (hit_port != port_reg) port_table_reg[idx] <= port_reg;
                                out_data_reg <= pack_out(ST_OK, 4'(idx), '0, '0, 1'b0, '0, '0);
                                out_last_reg <= 1'b1; out_valid_reg <= 1'b1; state_reg <= S_IDLE;
                            end
                        end
                        MODE_UNBIND:
                        begin
                            if (scan_done)
                            begin
                                out_data_reg <= pack_out(ST_UNBOUND, 4'd0, '0, '0, 1'b0, '0, '0);
                                out_last_reg <= 1'b1; out_valid_reg <= 1'b1; state_reg <= S_IDLE;
                            end
                            else if (hit_port == port_reg)
                            begin
                                port_table_reg[idx] <= '0;
                                wptr_reg[idx] <= '0; rptr_reg[idx] <= '0;
                                out_data_reg <= pack_out(ST_OK, 4'(idx), '0, '0, 1'b0, '0, '0);
                                out_last_reg <= 1'b1; out_valid_reg <= 1'b1; state_reg <= S_IDLE;
                            end
                        end
                        default:
                        begin
                            if (wr_en) state_reg <= S_IDLE;
                        end
                    endcase
                end
                S_RDLEN:
                begin
                    if ({1'b0, r_slot_reg} >= 5'(PORT_SLOTS))
                    begin
                        out_data_reg <= pack_out(ST_UNBOUND, r_slot_reg, '0, '0, 1'b0, '0, '0);
                        out_last_reg <= 1'b1; out_valid_reg <= 1'b1; state_reg <= S_IDLE;
                    end
                    else if (wptr_reg[r_slot_reg[SW-1:0]] == rptr_reg[r_slot_reg[SW-1:0]])
                    begin
                        out_data_reg <= pack_out(ST_EMPTY, r_slot_reg, '0, '0, 1'b0, '0, '0);
                        out_last_reg <= 1'b1; out_valid_reg <= 1'b1; state_reg <= S_IDLE;
                    end
                    else
                    begin
                        r_ent_reg <= ent_of(r_slot_reg[SW-1:0], rptr_reg[r_slot_reg[SW-1:0]]);
                        rptr_reg[r_slot_reg[SW-1:0]] <= inc_ptr(rptr_reg[r_slot_reg[SW-1:0]]);
                        r_k_reg <= '0;
                        state_reg <= S_RDSET;
                    end
                end
                S_RDSET:
                begin
                    // wait for entry read
                    state_reg <= S_RDBYTE;
                end
                S_RDBYTE:
                begin
                    if (r_k_reg == 7'd0)
                    begin
                        logic [6:0] n;
                        n = (rd_len_reg > CAP) ? CAP : rd_len_reg;
                        if (r_limit_reg < 16'(n)) n = 7'(r_limit_reg);
                        r_n_reg <= n;
                        if (n == 7'd0)
                        begin
                            out_data_reg <= pack_out(ST_OK, r_slot_reg, '0, '0, 1'b0,
                                                     rd_ip_reg, rd_sport_reg);
                            out_last_reg <= 1'b1; out_valid_reg <= 1'b1; state_reg <= S_IDLE;
                        end
                        else state_reg <= S_EMIT;
                    end
                    else state_reg <= S_EMIT;
                end
                S_EMIT:
                begin
                    if (!out_valid_reg || m_tready)
                    begin
                        out_data_reg <= pack_out(ST_OK, r_slot_reg, r_n_reg, rd_byte_reg, 1'b1,
                                                 rd_ip_reg, rd_sport_reg);
                        out_last_reg <= (r_k_reg + 7'd1 == r_n_reg);
                        out_valid_reg <= 1'b1;
                        r_k_reg <= r_k_reg + 7'd1;
                        state_reg <= (r_k_reg + 7'd1 == r_n_reg) ? S_IDLE : S_RDSET;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
        s_tready |-> (state_reg == S_IDLE))
        else $error("ready outside idle");
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("output changed under stall");
    a_emit_count: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_EMIT) |-> (r_k_reg < r_n_reg))
        else $error("byte index past length");
endmodule
`default_nettype wire
